// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker of the watchdog monitor.
// No dependencies; take in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define WDM_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WDM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wdm_pkg.sv =====
// Shared types and constants of the multi-client watchdog monitor.
// No dependencies; used by the cell, the cell row, the core and the checker.
package wdm_pkg;

  // Sizing
  localparam int MAX_CLIENTS   = 8;
  localparam int NUM_WATCHDOGS = 2;
  localparam int SLOT_W        = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  // Field widths
  localparam int REQ_W     = 2;
  localparam int ID_W      = 8;
  localparam int LIMIT_W   = 16;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int ASSIGN_W  = 3;
  localparam int FEED_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Watchdogs that exist at all
  localparam logic [FEED_W-1:0] FEED_MASK = FEED_W'((1 << NUM_WATCHDOGS) - 1);

  // Configuration register values after reset
  localparam logic [LIMIT_W-1:0] INTERVAL_RST = 16'd10;
  localparam logic [FEED_W-1:0]  ENABLE_RST   = 2'd3;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 2'd0,
    REQ_REGISTER = 2'd1,
    REQ_CHECKIN  = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_ID  = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_NOT_REG = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_INTERVAL = 2'd0,
    CFG_WDG_ENABLE     = 2'd1
  } cfg_idx_e;

  // Slot write command broadcast to every cell
  typedef struct packed {
    logic               reg_en;  // register: claim slot, load limit and stamp
    logic               chk_en;  // check-in: restamp slot
    logic [LIMIT_W-1:0] limit;
  } wdm_cmd_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic over;  // some slot seen so far has overrun
  } wdm_tok_t;

endpackage

// ===== hdl/multi_client_watchdog_monitor_core.sv =====
// Multi-client watchdog monitor: request decode, millisecond time base, scan control.
// Depends on wdm_pkg and wdm_chain.
//
// Supervises up to MAX_CLIENTS clients, one per cell of a slot row. Items are taken one
// at a time. Register, check-in, unknown requests and ticks that do not start a scan
// deliver their transaction into the output register at the accepting edge. A tick that
// starts a scan launches the scan token from a register; it steps through one slot cell
// per cycle, each cell folding in its own overrun test, and the result is written when
// the token leaves the last cell, or later from S_HOLD if the output register is held.
// The next item is accepted as soon as the previous result has reached the output
// register and that register is free or being drained. Slot storage needs no clearing
// after reset; the configuration port is always ready.
module multi_client_watchdog_monitor_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wdm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wdm_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [wdm_pkg::REQ_W-1:0]         req_type_i,
  input  logic [wdm_pkg::ID_W-1:0]          client_id_i,
  input  logic [wdm_pkg::LIMIT_W-1:0]       timeout_ms_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wdm_pkg::STATUS_W-1:0]      status_o,
  output logic [wdm_pkg::ASSIGN_W-1:0]      assigned_id_o,
  output logic [wdm_pkg::FEED_W-1:0]        feed_strobe_o,
  output logic                              timeout_flag_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_e;

  state_e                                state_q, state_d;
  logic [wdm_pkg::TIME_W-1:0]            now_q, now_d;
  logic [wdm_pkg::TIME_W-1:0]            elapsed_q, elapsed_d;
  logic                                  overrun_q, overrun_d;
  logic                                  scan_go_q, scan_go_d;
  logic [wdm_pkg::LIMIT_W-1:0]           interval_q, interval_d;
  logic [wdm_pkg::FEED_W-1:0]            enable_q, enable_d;
  logic                                  out_valid_q, out_valid_d;
  wdm_pkg::status_e                      out_status_q, out_status_d;
  logic [wdm_pkg::ASSIGN_W-1:0]          out_assigned_q, out_assigned_d;
  logic [wdm_pkg::FEED_W-1:0]            out_feed_q, out_feed_d;
  logic                                  out_flag_q, out_flag_d;

  logic                                  in_accept;
  logic                                  out_free;
  logic                                  scan_due;
  logic                                  id_ok;
  logic                                  found;
  logic                                  chk_used;
  logic [wdm_pkg::SLOT_W-1:0]            free_idx;
  logic [wdm_pkg::MAX_CLIENTS-1:0]       used;
  logic [wdm_pkg::MAX_CLIENTS-1:0]       free_onehot;
  logic [wdm_pkg::MAX_CLIENTS-1:0]       chk_onehot;
  logic [wdm_pkg::MAX_CLIENTS-1:0]       sel;
  wdm_pkg::wdm_cmd_t                     cmd;
  wdm_pkg::wdm_tok_t                     tok_in;
  wdm_pkg::wdm_tok_t                     tok_out;
  wdm_pkg::req_e                         req;

  // Handshakes
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign req         = wdm_pkg::req_e'(req_type_i);

  // Scan interval test: elapsed_q tracks now minus the last scan time
  assign scan_due = (elapsed_q + 32'd1) >=
                    {{(wdm_pkg::TIME_W-wdm_pkg::LIMIT_W){1'b0}}, interval_q};

  // Lowest free slot and check-in slot select
  assign free_onehot = ~used & (used + 1'b1);
  assign found       = ~&used;
  assign id_ok       = client_id_i < wdm_pkg::ID_W'(wdm_pkg::MAX_CLIENTS);
  assign chk_used    = |(used & chk_onehot);

  always_comb begin
    free_idx = '0;
    for (int k = wdm_pkg::MAX_CLIENTS - 1; k >= 0; k--) begin
      if (!used[k]) begin
        free_idx = wdm_pkg::SLOT_W'(k);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < wdm_pkg::MAX_CLIENTS; k++) begin
      chk_onehot[k] = (client_id_i == wdm_pkg::ID_W'(k));
    end
  end

  // Slot write command, issued at the accepting edge
  always_comb begin
    cmd.reg_en = in_accept && (req == wdm_pkg::REQ_REGISTER) && found;
    cmd.chk_en = in_accept && (req == wdm_pkg::REQ_CHECKIN) && id_ok && chk_used;
    cmd.limit  = timeout_ms_i;
    sel        = (req == wdm_pkg::REQ_REGISTER) ? free_onehot : chk_onehot;
  end

  assign tok_in.valid = scan_go_q;
  assign tok_in.over  = 1'b0;

  wdm_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sel_i  (sel),
    .now_i  (now_q),
    .tok_i  (tok_in),
    .tok_o  (tok_out),
    .used_o (used)
  );

  // Next state, time base and result
  always_comb begin
    state_d        = state_q;
    now_d          = now_q;
    elapsed_d      = elapsed_q;
    overrun_d      = overrun_q;
    scan_go_d      = 1'b0;
    interval_d     = interval_q;
    enable_d       = enable_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_status_d   = out_status_q;
    out_assigned_d = out_assigned_q;
    out_feed_d     = out_feed_q;
    out_flag_d     = out_flag_q;

    // configuration writes; the host must issue them with no transaction in flight, the block does not enforce it
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wdm_pkg::CFG_CHECK_INTERVAL: interval_d = cfg_data_i;
        wdm_pkg::CFG_WDG_ENABLE:     enable_d   = cfg_data_i[wdm_pkg::FEED_W-1:0];
        default:                     ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_d    = 1'b1;
          out_status_d   = wdm_pkg::STATUS_OK;
          out_assigned_d = '0;
          out_feed_d     = '0;
          out_flag_d     = overrun_q;
          unique case (req)
            wdm_pkg::REQ_TICK: begin
              now_d = now_q + 32'd1;
              if (scan_due) begin
                elapsed_d   = '0;
                scan_go_d   = 1'b1;
                out_valid_d = 1'b0;
                state_d     = S_SCAN;
              end else begin
                elapsed_d  = elapsed_q + 32'd1;
                out_feed_d = overrun_q ? '0 : (enable_q & wdm_pkg::FEED_MASK);
              end
            end
            wdm_pkg::REQ_REGISTER: begin
              if (found) begin
                out_assigned_d = wdm_pkg::ASSIGN_W'(free_idx);
              end else begin
                out_status_d = wdm_pkg::STATUS_FULL;
              end
            end
            wdm_pkg::REQ_CHECKIN: begin
              if (!id_ok) begin
                out_status_d = wdm_pkg::STATUS_BAD_ID;
              end else if (!chk_used) begin
                out_status_d = wdm_pkg::STATUS_NOT_REG;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (tok_out.valid) begin
          overrun_d = tok_out.over;
          if (out_free) begin
            out_valid_d    = 1'b1;
            out_status_d   = wdm_pkg::STATUS_OK;
            out_assigned_d = '0;
            out_feed_d     = tok_out.over ? '0 : (enable_q & wdm_pkg::FEED_MASK);
            out_flag_d     = tok_out.over;
            state_d        = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_status_d   = wdm_pkg::STATUS_OK;
          out_assigned_d = '0;
          out_feed_d     = overrun_q ? '0 : (enable_q & wdm_pkg::FEED_MASK);
          out_flag_d     = overrun_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      now_q          <= '0;
      elapsed_q      <= '0;
      overrun_q      <= 1'b0;
      scan_go_q      <= 1'b0;
      interval_q     <= wdm_pkg::INTERVAL_RST;
      enable_q       <= wdm_pkg::ENABLE_RST;
      out_valid_q    <= 1'b0;
      out_status_q   <= wdm_pkg::STATUS_OK;
      out_assigned_q <= '0;
      out_feed_q     <= '0;
      out_flag_q     <= 1'b0;
    end else begin
      state_q        <= state_d;
      now_q          <= now_d;
      elapsed_q      <= elapsed_d;
      overrun_q      <= overrun_d;
      scan_go_q      <= scan_go_d;
      interval_q     <= interval_d;
      enable_q       <= enable_d;
      out_valid_q    <= out_valid_d;
      out_status_q   <= out_status_d;
      out_assigned_q <= out_assigned_d;
      out_feed_q     <= out_feed_d;
      out_flag_q     <= out_flag_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign assigned_id_o  = out_assigned_q;
  assign feed_strobe_o  = out_feed_q;
  assign timeout_flag_o = out_flag_q;

endmodule

// ===== hdl/wdm_cell.sv =====
// One client slot: used bit, allowed silence, last check-in stamp and one scan stage.
// Depends on wdm_pkg.
module wdm_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wdm_pkg::wdm_cmd_t            cmd_i,
  input  logic                         sel_i,
  input  logic [wdm_pkg::TIME_W-1:0]   now_i,
  input  wdm_pkg::wdm_tok_t            tok_i,
  output wdm_pkg::wdm_tok_t            tok_o,
  output logic                         used_o
);

  logic                          used_q;
  logic [wdm_pkg::LIMIT_W-1:0]   limit_q;
  logic [wdm_pkg::TIME_W-1:0]    seen_q;
  wdm_pkg::wdm_tok_t             tok_q;
  logic [wdm_pkg::TIME_W-1:0]    elapsed;
  logic                          hit;

  // Overrun test for this slot, wrap-around elapsed time
  assign elapsed = now_i - seen_q;
  assign hit     = used_q && (elapsed >= {{(wdm_pkg::TIME_W-wdm_pkg::LIMIT_W){1'b0}}, limit_q});

  // Control: used bit and scan stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      if (sel_i && cmd_i.reg_en) begin
        used_q <= 1'b1;
      end
      tok_q.valid <= tok_i.valid;
      tok_q.over  <= tok_i.over | hit;
    end
  end

  // Slot payload: limit written on register, stamp on register and check-in
  always_ff @(posedge clk_i) begin
    if (sel_i && cmd_i.reg_en) begin
      limit_q <= cmd_i.limit;
    end
    if (sel_i && (cmd_i.reg_en || cmd_i.chk_en)) begin
      seen_q <= now_i;
    end
  end

  assign tok_o  = tok_q;
  assign used_o = used_q;

endmodule

// ===== hdl/wdm_chain.sv =====
// Row of client slot cells; the scan token walks one cell per cycle.
// Depends on wdm_pkg and wdm_cell.
module wdm_chain (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wdm_pkg::wdm_cmd_t                cmd_i,
  input  logic [wdm_pkg::MAX_CLIENTS-1:0]  sel_i,
  input  logic [wdm_pkg::TIME_W-1:0]       now_i,
  input  wdm_pkg::wdm_tok_t                tok_i,
  output wdm_pkg::wdm_tok_t                tok_o,
  output logic [wdm_pkg::MAX_CLIENTS-1:0]  used_o
);

  // tok[k] feeds cell k, tok[MAX_CLIENTS] leaves the row
  wdm_pkg::wdm_tok_t tok [wdm_pkg::MAX_CLIENTS+1];

  assign tok[0] = tok_i;

  for (genvar k = 0; k < wdm_pkg::MAX_CLIENTS; k++) begin : g_cell
    wdm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_i),
      .sel_i  (sel_i[k]),
      .now_i  (now_i),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .used_o (used_o[k])
    );
  end

  assign tok_o = tok[wdm_pkg::MAX_CLIENTS];

endmodule

// ===== hdl/wdm_checker.sv =====
// Port-level checks of the watchdog monitor core, attached by bind.
// Depends on wdm_pkg, assert_macros.svh and multi_client_watchdog_monitor_core.
`include "assert_macros.svh"

module wdm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [wdm_pkg::REQ_W-1:0]         req_type_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [wdm_pkg::STATUS_W-1:0]      status_o,
  input logic [wdm_pkg::ASSIGN_W-1:0]      assigned_id_o,
  input logic [wdm_pkg::FEED_W-1:0]        feed_strobe_o,
  input logic                              timeout_flag_o
);

  logic out_held;
  logic quick_req;
  logic flagged;
  logic no_feed;
  logic err_res;
  logic clean_res;

  assign out_held  = out_valid_o && out_stall_i;
  assign quick_req = in_valid_i && !in_stall_o && (req_type_i != wdm_pkg::REQ_TICK);
  assign flagged   = out_valid_o && timeout_flag_o;
  assign no_feed   = (feed_strobe_o == '0);
  assign err_res   = out_valid_o && (status_o != wdm_pkg::STATUS_OK);
  assign clean_res = no_feed && (assigned_id_o == '0);

  // A stalled result stays offered
  `WDM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o, "result dropped")

  // Non-tick requests answer in the next cycle
  `WDM_ASSERT_NEXT(a_quick_answer, clk_i, rst_ni, quick_req, out_valid_o, "late answer")

  // No watchdog is fed while an overrun is flagged
  `WDM_ASSERT_SAME(a_no_feed_on_overrun, clk_i, rst_ni, flagged, no_feed, "fed on overrun")

  // Error results carry neither a slot nor a feed
  `WDM_ASSERT_SAME(a_error_clean, clk_i, rst_ni, err_res, clean_res, "error not clean")

endmodule

bind multi_client_watchdog_monitor_core wdm_checker u_wdm_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the multi-client watchdog monitor core.
// Depends on wdm_pkg and the core RTL; a built-in predictor supplies the expected replies.
module testbench;
  import wdm_pkg::*;

  // One request transaction and the reply it should produce
  typedef struct {
    req_e               req;
    logic [ID_W-1:0]    id;
    logic [LIMIT_W-1:0] tmo;
  } request_t;

  typedef struct {
    status_e             status;
    logic [ASSIGN_W-1:0] slot;
    logic [FEED_W-1:0]   feed;
    logic                flag;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [REQ_W-1:0]     req_type_i;
  logic [ID_W-1:0]      client_id_i;
  logic [LIMIT_W-1:0]   timeout_ms_i;

  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STATUS_W-1:0]  status_o;
  logic [ASSIGN_W-1:0]  assigned_id_o;
  logic [FEED_W-1:0]    feed_strobe_o;
  logic                 timeout_flag_o;

  // Predictor state: time base, slot table, scan result and register copies
  logic [TIME_W-1:0]    now_ms_q;
  logic [TIME_W-1:0]    last_scan_q;
  logic                 slot_busy [MAX_CLIENTS];
  logic [LIMIT_W-1:0]   slot_limit [MAX_CLIENTS];
  logic [TIME_W-1:0]    slot_stamp [MAX_CLIENTS];
  logic                 overrun_q;
  logic [CFG_DAT_W-1:0] interval_cfg;
  logic [FEED_W-1:0]    enable_cfg;

  request_t pending_requests [$];
  reply_t   predicted_replies [$];

  request_t on_bus;
  int       gap_left = 0;
  bit       tx_calm = 1'b0;
  bit       rx_calm = 1'b0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       run_left = 0;
  int       stall_left = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       claimed_slots = 0;
  reply_t   exp_reply;

  multi_client_watchdog_monitor_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .client_id_i    (client_id_i),
    .timeout_ms_i   (timeout_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .assigned_id_o  (assigned_id_o),
    .feed_strobe_o  (feed_strobe_o),
    .timeout_flag_o (timeout_flag_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Expected reply for one accepted request; advances the predictor state
  function automatic reply_t watchdog_reply(request_t rq);
    reply_t rsp;
    logic   over;
    logic   found;
    rsp.status = STATUS_OK;
    rsp.slot   = '0;
    rsp.feed   = '0;
    case (rq.req)
      REQ_TICK: begin
        now_ms_q = now_ms_q + 1;
        // wrap-around elapsed time against the scan interval
        if (TIME_W'(now_ms_q - last_scan_q) >= TIME_W'(interval_cfg)) begin
          over = 1'b0;
          for (int k = 0; k < MAX_CLIENTS; k++) begin
            if (slot_busy[k] && TIME_W'(now_ms_q - slot_stamp[k]) >= TIME_W'(slot_limit[k]))
              over = 1'b1;
          end
          overrun_q   = over;
          last_scan_q = now_ms_q;
        end
        if (!overrun_q) rsp.feed = enable_cfg & FEED_MASK;
      end
      REQ_REGISTER: begin
        // lowest free slot wins
        found = 1'b0;
        for (int k = 0; k < MAX_CLIENTS; k++) begin
          if (!found && !slot_busy[k]) begin
            slot_busy[k]  = 1'b1;
            slot_limit[k] = rq.tmo;
            slot_stamp[k] = now_ms_q;
            rsp.slot      = ASSIGN_W'(k);
            found         = 1'b1;
          end
        end
        if (!found) rsp.status = STATUS_FULL;
      end
      REQ_CHECKIN: begin
        if (rq.id >= MAX_CLIENTS) rsp.status = STATUS_BAD_ID;
        else if (!slot_busy[rq.id[SLOT_W-1:0]]) rsp.status = STATUS_NOT_REG;
        else slot_stamp[rq.id[SLOT_W-1:0]] = now_ms_q;
      end
      default: ;
    endcase
    rsp.flag = overrun_q;
    return rsp;
  endfunction

  // Queue one request; registrations are counted so the table fill is known
  task automatic push_request(req_e req, logic [ID_W-1:0] id, logic [LIMIT_W-1:0] tmo);
    request_t rq;
    rq.req = req;
    rq.id  = id;
    rq.tmo = tmo;
    if (req == REQ_REGISTER && claimed_slots < MAX_CLIENTS) claimed_slots++;
    pending_requests.push_back(rq);
  endtask

  // Random traffic: mostly ticks and check-ins, rare registrations that keep one slot free
  task automatic push_random(int count);
    int r;
    logic [LIMIT_W-1:0] tmo;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_request(REQ_TICK, ID_W'($urandom), LIMIT_W'($urandom));
      end else if (r < 90) begin
        if ($urandom_range(0, 99) < 85)
          push_request(REQ_CHECKIN, ID_W'($urandom_range(0, MAX_CLIENTS - 1)),
                       LIMIT_W'($urandom));
        else
          push_request(REQ_CHECKIN, ID_W'($urandom_range(MAX_CLIENTS, 255)),
                       LIMIT_W'($urandom));
      end else if (r < 94) begin
        push_request(REQ_NONE, ID_W'($urandom), LIMIT_W'($urandom));
      end else if (r == 99 && claimed_slots < MAX_CLIENTS - 1) begin
        // small limits give overruns that check-ins can clear; large ones cover the upper bits
        tmo = ($urandom_range(0, 3) != 0) ? LIMIT_W'($urandom_range(4, 40))
                                          : LIMIT_W'($urandom_range(41, 65535));
        push_request(REQ_REGISTER, ID_W'($urandom), tmo);
      end else begin
        push_request(REQ_TICK, ID_W'($urandom), LIMIT_W'($urandom));
      end
    end
  endtask

  // Block until every queued request has gone out and every reply has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() > 0 || in_valid_i || predicted_replies.size() > 0);
  endtask

  // One configuration write transaction; the predictor copy follows on the handshake
  task automatic write_register(cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CHECK_INTERVAL: interval_cfg = data;
      CFG_WDG_ENABLE:     enable_cfg   = data[FEED_W-1:0];
      default: ;
    endcase
  endtask

  // Request driver: pops queued requests, holds each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= REQ_TICK;
      client_id_i  <= '0;
      timeout_ms_i <= '0;
      gap_left     = 0;
    end else begin
      if (in_valid_i && !in_stall_o) predicted_replies.push_back(watchdog_reply(on_bus));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          on_bus       = pending_requests.pop_front();
          req_type_i   <= on_bus.req;
          client_id_i  <= on_bus.id;
          timeout_ms_i <= on_bus.tmo;
          in_valid_i   <= 1'b1;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          gap_left = tx_calm ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result stall: random bursts, plus one long hold-off that backs up the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   = 0;
      run_left    = 0;
      stall_left  = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      run_left   = rx_calm ? $urandom_range(20, 80) : $urandom_range(0, 6);
      stall_left = rx_calm ? 0 : idle_len();
      out_stall_i <= 1'b0;
    end
  end

  // Reply monitor: each accepted transaction is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_replies.size() == 0) begin
        $error("reply with no request outstanding");
        mismatches++;
      end else begin
        exp_reply = predicted_replies.pop_front();
        if (status_o !== exp_reply.status) begin
          $error("status: expected %0d, got %0d", exp_reply.status, status_o);
          mismatches++;
        end
        if (assigned_id_o !== exp_reply.slot) begin
          $error("assigned_id: expected %0d, got %0d", exp_reply.slot, assigned_id_o);
          mismatches++;
        end
        if (feed_strobe_o !== exp_reply.feed) begin
          $error("feed_strobe: expected %0d, got %0d", exp_reply.feed, feed_strobe_o);
          mismatches++;
        end
        if (timeout_flag_o !== exp_reply.flag) begin
          $error("timeout_flag: expected %0d, got %0d", exp_reply.flag, timeout_flag_o);
          mismatches++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Sequence: reset, directed opener, random phases under several settings, closing checks
  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_CHECK_INTERVAL;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_TICK;
    client_id_i  = '0;
    timeout_ms_i = '0;
    out_stall_i  = 1'b0;
    now_ms_q     = '0;
    last_scan_q  = '0;
    overrun_q    = 1'b0;
    interval_cfg = INTERVAL_RST;
    enable_cfg   = ENABLE_RST;
    for (int k = 0; k < MAX_CLIENTS; k++) begin
      slot_busy[k]  = 1'b0;
      slot_limit[k] = '0;
      slot_stamp[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // opener at reset settings: errors, empty slots, ignored codes, first registrations
    push_request(REQ_TICK, 8'd0, 16'd0);
    push_request(REQ_CHECKIN, 8'd0, 16'd0);
    push_request(REQ_CHECKIN, 8'(MAX_CLIENTS), 16'd0);
    push_request(REQ_CHECKIN, 8'hFF, 16'hFFFF);
    push_request(REQ_NONE, 8'hFF, 16'hFFFF);
    push_request(REQ_NONE, 8'd0, 16'd0);
    push_request(REQ_REGISTER, 8'd0, 16'hFFFF);
    push_request(REQ_REGISTER, 8'hFF, 16'd12);
    push_request(REQ_CHECKIN, 8'd0, 16'd0);
    push_request(REQ_CHECKIN, 8'd1, 16'd0);
    push_request(REQ_CHECKIN, 8'(MAX_CLIENTS - 1), 16'd0);
    repeat (10) push_request(REQ_TICK, 8'd0, 16'd0);
    wait_drained();

    // scan on every tick, one watchdog enabled
    write_register(CFG_CHECK_INTERVAL, 16'd1);
    write_register(CFG_WDG_ENABLE, 16'd2);
    push_random(250);
    wait_drained();

    // zero interval, the long receiver hold-off falls in this phase
    write_register(CFG_CHECK_INTERVAL, 16'd0);
    write_register(CFG_WDG_ENABLE, 16'd1);
    push_random(250);
    wait_drained();

    // scans effectively never due, feeding disabled
    write_register(CFG_CHECK_INTERVAL, 16'hFFFF);
    write_register(CFG_WDG_ENABLE, 16'd0);
    push_random(150);
    wait_drained();

    write_register(CFG_CHECK_INTERVAL, 16'd7);
    write_register(CFG_WDG_ENABLE, 16'd3);
    push_random(300);
    wait_drained();

    // closing: fill the table, zero limit in the top slot, then a full-table register
    write_register(CFG_CHECK_INTERVAL, 16'd3);
    while (claimed_slots < MAX_CLIENTS - 1)
      push_request(REQ_REGISTER, 8'd0, LIMIT_W'($urandom_range(20, 60)));
    push_request(REQ_REGISTER, 8'd0, 16'd0);
    push_request(REQ_REGISTER, 8'hFF, 16'd100);
    repeat (4) push_request(REQ_TICK, 8'd0, 16'd0);
    push_request(REQ_CHECKIN, 8'(MAX_CLIENTS - 1), 16'd0);
    repeat (3) push_request(REQ_TICK, 8'd0, 16'd0);
    push_request(REQ_CHECKIN, 8'd200, 16'd0);
    push_request(REQ_NONE, 8'd0, 16'd0);
    wait_drained();

    // leave room for stray replies, such as the result of a scan tick
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
